// ----- hw/rtl/deq_pkg.sv -----
// deq_pkg: shared types and codes for the double-ended queue
// request and result payload structs, opcode and status codes, cell control
// no dependencies
package deq_pkg;

  localparam int DEF_DEPTH      = 16;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int FIELD_W        = 32;
  localparam int COUNT_W        = 5;

  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REVERSE    = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [FIELD_W-1:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] front_value;
    logic [FIELD_W-1:0] back_value;
    logic [COUNT_W-1:0] item_count;
    logic [1:0]         status;
  } res_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
    logic at_first;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/double_ended_queue.sv -----
// double_ended_queue: top level of the bounded deque
// chain of deq_cell entries, count, reversed flag and result register
// depends on deq_pkg and deq_cell
//
// A bounded deque of DEPTH entries held in a row of cells that shift as a
// unit: the physical first entry always sits in cell 0, so a push or pop at
// that end moves every entry by one cell, and a push or pop at the other
// end touches only the boundary cell. Reverse flips a flag that swaps
// which physical end is the logical front. Every request yields one
// result, so a new request is taken each cycle while the result side
// keeps up; the front and back values are read straight from the cells,
// and the physical last value goes through a DEPTH-wide one-hot select.
// Pop on empty reports status empty, push on full reports status full and
// drops the value; neither changes the contents. Front and back values read
// zero while the deque is empty.
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  deq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output deq_pkg::res_t res
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  is_push;
  logic                  is_pop;
  logic                  logical_front;
  logic                  full;
  logic                  empty;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] push_data;

  logic [DATA_WIDTH-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]      cell_occ;
  logic [DEPTH-1:0]      cell_last;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  reversed;
  logic                  reversed_next;
  status_t               status;
  status_t               status_next;
  logic                  res_valid_next;

  logic [DATA_WIDTH-1:0] first_value;
  logic [DATA_WIDTH-1:0] last_value;
  logic [DATA_WIDTH-1:0] front_sel;
  logic [DATA_WIDTH-1:0] back_sel;

  // request handshake: hold off only while a result waits
  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign full      = cell_occ[DEPTH-1];
  assign empty     = !cell_occ[0];
  assign push_data = DATA_WIDTH'(cmd.data_in);

  // decode the opcode
  always_comb begin
    is_push       = 1'b0;
    is_pop        = 1'b0;
    logical_front = 1'b0;
    reversed_next = reversed;
    status_next   = ST_OK;
    unique case (opcode_t'(cmd.opcode))
      OP_PUSH_FRONT: begin
        logical_front = 1'b1;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          is_push = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          is_push = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        logical_front = 1'b1;
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          is_pop = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          is_pop = 1'b1;
        end
      end
      OP_REVERSE: begin
        reversed_next = !reversed;
      end
      default: begin
      end
    endcase
  end

  // cell control broadcast
  always_comb begin
    ctrl.push     = accept && is_push;
    ctrl.pop      = accept && is_pop;
    ctrl.at_first = logical_front != reversed;
  end

  // count follows the occupancy change
  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  // chain of cells, cell 0 holds the physical first entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lv;
    logic                  lo;
    logic [DATA_WIDTH-1:0] rv;
    logic                  ro;

    if (i == 0) begin : g_head
      assign lv = push_data;
      assign lo = 1'b1;
    end else begin : g_mid_l
      assign lv = cell_value[i-1];
      assign lo = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = cell_value[i];
      assign ro = 1'b0;
    end else begin : g_mid_r
      assign rv = cell_value[i+1];
      assign ro = cell_occ[i+1];
    end

    deq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .push_data  (push_data),
      .left_value (lv),
      .left_occ   (lo),
      .right_value(rv),
      .right_occ  (ro),
      .value      (cell_value[i]),
      .occ        (cell_occ[i]),
      .is_last    (cell_last[i])
    );
  end

  // physical ends; the last entry is picked by its one-hot marker
  assign first_value = cell_occ[0] ? cell_value[0] : '0;

  always_comb begin
    last_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      last_value = last_value | (cell_value[i] & {DATA_WIDTH{cell_last[i]}});
    end
  end

  assign front_sel = reversed ? last_value : first_value;
  assign back_sel  = reversed ? first_value : last_value;

  // control and status registers
  always_comb begin
    res_valid_next = res_valid;
    if (accept) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      reversed  <= 1'b0;
      res_valid <= 1'b0;
      status    <= ST_OK;
    end else begin
      res_valid <= res_valid_next;
      if (accept) begin
        count    <= count_next;
        reversed <= reversed_next;
        status   <= status_next;
      end
    end
  end

  // result payload reads the state left by the last request
  always_comb begin
    res.front_value = FIELD_W'(front_sel);
    res.back_value  = FIELD_W'(back_sel);
    res.item_count  = COUNT_W'(count);
    res.status      = status;
  end

endmodule

// ----- hw/rtl/deq_cell.sv -----
// deq_cell: one storage cell of the shifting deque chain
// holds one entry and its occupied bit, trades data with both neighbors
// depends on deq_pkg
module deq_cell #(
  parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  deq_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic [DATA_WIDTH-1:0] left_value,
  input  logic                  left_occ,
  input  logic [DATA_WIDTH-1:0] right_value,
  input  logic                  right_occ,
  output logic [DATA_WIDTH-1:0] value,
  output logic                  occ,
  output logic                  is_last
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] value_next;
  logic                  occ_next;

  // occupancy is a thermometer: pushes grow it, pops shrink it
  always_comb begin
    occ_next = occ;
    if (ctrl.push) begin
      occ_next = left_occ;
    end else if (ctrl.pop) begin
      occ_next = right_occ;
    end
  end

  // data moves right on a first-end push, left on a first-end pop; a last-end push fills the first free cell
  always_comb begin
    value_next = value;
    if (ctrl.push && ctrl.at_first) begin
      value_next = left_value;
    end else if (ctrl.push && !occ && left_occ) begin
      value_next = push_data;
    end else if (ctrl.pop && ctrl.at_first) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign is_last = occ && !right_occ;

endmodule

// ----- tb/double_ended_queue_tb.sv -----
// double_ended_queue_tb: self-checking testbench for the bounded deque
// drives requests, predicts every result from a ring-store model and checks it
// depends on deq_pkg and double_ended_queue
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 8;

  // opcodes outside the enum, both behave as no operation
  localparam logic [2:0] OPC_SPARE_LO = 3'd6;
  localparam logic [2:0] OPC_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic res_valid;
  logic res_stall;
  res_t res;

  double_ended_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // deque model state: ring store, physical head, fill and reversed flag
  logic [31:0] ring [DEPTH];
  logic [3:0]  head;
  logic [4:0]  fill;
  bit          flipped;

  res_t        expected_results[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          sender_idle_on;
  bit          receiver_idle_on;
  bit          hold_req;
  bit          growing;

  function automatic void deque_clear();
    for (int i = 0; i < DEPTH; i++) ring[i] = '0;
    head    = '0;
    fill    = '0;
    flipped = 1'b0;
  endfunction

  // apply one request to the model and return the result it yields
  function automatic res_t deque_next(logic [2:0] op, logic [31:0] d);
    res_t       r;
    logic       at_first;
    logic [3:0] last;
    r        = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          at_first = (op == OP_PUSH_FRONT) ^ flipped;
          if (at_first) begin
            head       = head - 4'd1;
            ring[head] = d;
          end else begin
            ring[4'(head + fill[3:0])] = d;
          end
          fill = fill + 5'd1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          at_first = (op == OP_POP_FRONT) ^ flipped;
          if (at_first) head = head + 4'd1;
          fill = fill - 5'd1;
          if (fill == 0) head = '0;
        end
      end
      OP_REVERSE: flipped = !flipped;
      default: ;
    endcase
    // logical ends swap while reversed, both read zero when empty
    if (fill != 0) begin
      last = 4'(head + 4'(fill - 5'd1));
      if (flipped) begin
        r.front_value = ring[last];
        r.back_value  = ring[head];
      end else begin
        r.front_value = ring[head];
        r.back_value  = ring[last];
      end
    end
    r.item_count = fill;
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [31:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 24) return 32'($urandom_range(0, 15));
    return $urandom;
  endfunction

  // opcode mix leans toward pushes while growing and pops while shrinking
  function automatic logic [2:0] pick_op(bit grow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return grow ? OP_PUSH_FRONT : OP_POP_FRONT;
    if (r < 70) return grow ? OP_PUSH_BACK : OP_POP_BACK;
    if (r < 80) return grow ? OP_POP_FRONT : OP_PUSH_FRONT;
    if (r < 90) return grow ? OP_POP_BACK : OP_PUSH_BACK;
    if (r < 95) return OP_REVERSE;
    if (r < 97) return OP_NONE;
    return $urandom_range(0, 1) ? OPC_SPARE_HI : OPC_SPARE_LO;
  endfunction

  // offer one request, hold it until taken, then record its result
  task automatic send_cmd(input logic [2:0] op, input logic [31:0] d);
    cmd_t        c;
    int unsigned gap;
    gap = sender_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    c.opcode  = op;
    c.data_in = d;
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    expected_results.push_back(deque_next(op, d));
  endtask

  task automatic send_random();
    if (fill == DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
    if (fill == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
    send_cmd(pick_op(growing), pick_data());
  endtask

  // pops on empty, reverse on empty, no-op and spare opcodes
  task automatic test_empty_queue();
    send_cmd(OP_POP_FRONT, '1);
    send_cmd(OP_POP_BACK, '0);
    send_cmd(OP_REVERSE, 32'h0000_0001);
    send_cmd(OP_NONE, '1);
    send_cmd(OPC_SPARE_LO, 32'h8000_0000);
    send_cmd(OPC_SPARE_HI, '0);
  endtask

  // fill from both ends, push on full at both ends, reverse while full
  task automatic test_full_queue();
    logic [31:0] pattern [4];
    pattern[0] = '0;
    pattern[1] = '1;
    pattern[2] = 32'hAAAA_AAAA;
    pattern[3] = 32'h5555_5555;
    for (int i = 0; i < DEPTH; i++) begin
      send_cmd(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
               (i < 4) ? pattern[i] : 32'(i * 32'h0101_0101));
    end
    send_cmd(OP_PUSH_FRONT, 32'hDEAD_0001);
    send_cmd(OP_PUSH_BACK, 32'hDEAD_0002);
    send_cmd(OP_REVERSE, '0);
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure_fill();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    growing          = 1'b1;
    hold_req         = 1'b1;
    repeat (40) send_random();
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
  endtask

  // random traffic in segments, idling switched on and off per segment
  task automatic test_random_mix();
    for (int seg = 0; seg < 10; seg++) begin
      sender_idle_on   = (seg % 3) != 2;
      receiver_idle_on = (seg % 4) != 3;
      repeat (50) send_random();
    end
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
  endtask

  // result side stall, with a long hold on request
  initial begin : result_stall_drive
    int unsigned run;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        run = HOLD_CYCLES;
      end else if (!receiver_idle_on) begin
        res_stall <= 1'b0;
        run = 1;
      end else if ($urandom_range(0, 99) < 65) begin
        res_stall <= 1'b0;
        run = $urandom_range(1, 6);
      end else begin
        res_stall <= 1'b1;
        run = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 30);
      end
      repeat (run - 1) @(posedge clk);
    end
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $time, res);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        report_field("front_value", want.front_value, res.front_value);
        report_field("back_value", want.back_value, res.back_value);
        report_field("item_count", 32'(want.item_count), 32'(res.item_count));
        report_field("status", 32'(want.status), 32'(res.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : run_tests
    rst              <= 1'b1;
    cmd_valid        <= 1'b0;
    cmd              <= '0;
    mismatches       = 0;
    cycle_count      = 0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    hold_req         = 1'b0;
    growing          = 1'b1;
    deque_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_full_queue();
    test_backpressure_fill();
    test_random_mix();

    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- double_ended_queue.f -----
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/double_ended_queue.sv
tb/double_ended_queue_tb.sv
